>>> src/sbms_pkg.sv
// Shared types and constants for the shared-buffer multi-stack.
// No dependencies; shared_buffer_multi_stack and sbms_exec import this package.
package sbms_pkg;

  localparam int DATA_W         = 32;
  localparam int SID_W          = 2;
  localparam int STACK_ID_RANGE = 4;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [SID_W-1:0]          stack_id;
    logic signed [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  popped_value;
  } result_t;

endpackage

>>> src/shared_buffer_multi_stack.sv
// Shared-buffer multi-stack: one beat per cycle; the result strobe comes from the execute stage.
// The accept edge reads the link and data RAMs into their read registers; the execute stage then
// updates the stacks and registers the result. busy never rises, so a new beat is taken every cycle.
// Reset (synchronous, active low) empties all stacks with no clearing pass: a fill
// count stands in for the initial free-list chain. The receiver cannot stall.
module shared_buffer_multi_stack #(
  parameter int NUM_STACKS = 4,
  parameter int DEPTH      = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [sbms_pkg::SID_W-1:0]          in_stack_id,
  input  logic signed [sbms_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic signed [sbms_pkg::DATA_W-1:0]  out_popped_value
);

  import sbms_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic              accept;
  item_t             in_item;
  logic              ex_valid_r;
  item_t             ex_item_r;
  logic [PW-1:0]     issue_slot;
  logic [AW-1:0]     rd_addr;
  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [PW-1:0]     link_wdata;
  logic              data_we;
  logic [AW-1:0]     data_waddr;
  logic [DATA_W-1:0] data_wdata;
  logic [PW-1:0]     link_q;
  logic [DATA_W-1:0] data_q;
  logic              link_byp_r;
  logic [PW-1:0]     link_byp_val_r;
  logic              data_byp_r;
  logic [DATA_W-1:0] data_byp_val_r;
  logic [PW-1:0]     link_rd;
  logic [DATA_W-1:0] data_rd;
  logic              res_valid;
  result_t           res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_item.cmd      = cmd_t'(in_cmd);
  assign in_item.stack_id = in_stack_id;
  assign in_item.value    = in_value;

  assign rd_addr = issue_slot[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else begin
      ex_valid_r <= accept;
    end
  end

  // A write landing on the same edge as the read is not seen by the RAM; keep it.
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item_r <= in_item;
    end
    link_byp_r     <= link_we && (link_waddr == rd_addr);
    link_byp_val_r <= link_wdata;
    data_byp_r     <= data_we && (data_waddr == rd_addr);
    data_byp_val_r <= data_wdata;
  end

  assign link_rd = link_byp_r ? link_byp_val_r : link_q;
  assign data_rd = data_byp_r ? data_byp_val_r : data_q;

  sbms_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_q)
  );

  sbms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (rd_addr),
    .rdata (data_q)
  );

  sbms_exec #(
    .NUM_STACKS (NUM_STACKS),
    .DEPTH      (DEPTH)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .ex_valid   (ex_valid_r),
    .ex_item    (ex_item_r),
    .link_rd    (link_rd),
    .data_rd    (data_rd),
    .lookup_cmd (in_item.cmd),
    .lookup_sid (in_stack_id),
    .issue_slot (issue_slot),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid        = res_valid;
  assign out_ok           = res.ok;
  assign out_popped_value = res.popped_value;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("accepted beat produced no result two cycles later");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ex_valid_r))
    else $error("result strobe without a beat in the execute stage");

  a_failed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_popped_value == '0))
    else $error("failed operation returned a nonzero value");

endmodule

>>> src/sbms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sbms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/sbms_exec.sv
// Execute stage: stack tops, free-list head and fill count, the push/pop
// update and the result register. Depends on sbms_pkg.
module sbms_exec #(
  parameter int NUM_STACKS = 4,
  parameter int DEPTH      = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ex_valid,
  input  sbms_pkg::item_t                 ex_item,
  input  logic [$clog2(DEPTH+1)-1:0]      link_rd,
  input  logic [sbms_pkg::DATA_W-1:0]     data_rd,
  input  sbms_pkg::cmd_t                  lookup_cmd,
  input  logic [sbms_pkg::SID_W-1:0]      lookup_sid,
  output logic [$clog2(DEPTH+1)-1:0]      issue_slot,
  output logic                            link_we,
  output logic [$clog2(DEPTH)-1:0]        link_waddr,
  output logic [$clog2(DEPTH+1)-1:0]      link_wdata,
  output logic                            data_we,
  output logic [$clog2(DEPTH)-1:0]        data_waddr,
  output logic [sbms_pkg::DATA_W-1:0]     data_wdata,
  output logic                            res_valid,
  output sbms_pkg::result_t               res
);

  import sbms_pkg::*;

  localparam int PW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int NTOP = (NUM_STACKS < STACK_ID_RANGE) ? NUM_STACKS : STACK_ID_RANGE;
  localparam logic [PW-1:0] SLOT_NULL = PW'(DEPTH);

  logic [PW-1:0] top_r [NTOP];
  logic [PW-1:0] top_nxt [NTOP];
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic          res_valid_r;
  result_t       res_r, res_nxt;

  logic          is_push;
  logic          sid_ok;
  logic [PW-1:0] cur_top;
  logic [PW-1:0] slot;
  logic          do_op;
  logic [PW-1:0] link_val;
  logic [PW-1:0] lk_top;

  always_comb begin
    cur_top = SLOT_NULL;
    sid_ok  = 1'b0;
    for (int i = 0; i < NTOP; i++) begin
      if (ex_item.stack_id == SID_W'(i)) begin
        cur_top = top_r[i];
        sid_ok  = 1'b1;
      end
    end
    is_push = (ex_item.cmd == CMD_PUSH);
    slot    = is_push ? free_head_r : cur_top;
    do_op   = ex_valid && sid_ok && (slot < SLOT_NULL);
    // Slots at or above the fill count were never handed out, so their link
    // is taken as the initial chain value of slot plus one, not read from the RAM.
    if (is_push && (slot >= fill_r)) begin
      link_val = PW'(slot + 1'b1);
    end else begin
      link_val = link_rd;
    end
  end

  always_comb begin
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    for (int i = 0; i < NTOP; i++) begin
      top_nxt[i] = top_r[i];
    end
    link_we    = 1'b0;
    link_wdata = free_head_r;
    data_we    = 1'b0;
    data_wdata = ex_item.value;
    res_nxt.ok           = do_op;
    res_nxt.popped_value = '0;
    if (do_op) begin
      link_we = 1'b1;
      for (int i = 0; i < NTOP; i++) begin
        if (ex_item.stack_id == SID_W'(i)) begin
          top_nxt[i] = is_push ? slot : link_val;
        end
      end
      if (is_push) begin
        free_head_nxt = link_val;
        if (slot == fill_r) begin
          fill_nxt = PW'(fill_r + 1'b1);
        end
        link_wdata = cur_top;
        data_we    = 1'b1;
      end else begin
        free_head_nxt        = slot;
        link_wdata           = free_head_r;
        res_nxt.popped_value = $signed(data_rd);
      end
    end
  end

  assign link_waddr = slot[AW-1:0];
  assign data_waddr = slot[AW-1:0];

  // Address for the next beat comes from the state as it will be after this one.
  always_comb begin
    lk_top = SLOT_NULL;
    for (int i = 0; i < NTOP; i++) begin
      if (lookup_sid == SID_W'(i)) begin
        lk_top = top_nxt[i];
      end
    end
    issue_slot = (lookup_cmd == CMD_PUSH) ? free_head_nxt : lk_top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NTOP; i++) begin
        top_r[i] <= SLOT_NULL;
      end
      free_head_r <= '0;
      fill_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NTOP; i++) begin
        top_r[i] <= top_nxt[i];
      end
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      res_valid_r <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SLOT_NULL)
    else $error("fill count past the store depth");

  a_empty_free_list: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == SLOT_NULL) |-> (fill_r == SLOT_NULL))
    else $error("free list empty while slots were never used");

  a_fresh_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (do_op && is_push && (free_head_r >= fill_r)) |-> (free_head_r == fill_r))
    else $error("push took an unused slot other than the fill count");

endmodule
